### hw/rtl/zcfm_pkg.sv
// ----------------------------------------------------------------------------
// zcfm_pkg
// Shared widths, limits and reset values of the zero crossing frequency meter.
// ----------------------------------------------------------------------------
package zcfm_pkg;

    localparam int SAMPLE_W = 24;
    localparam int RATE_W   = 18;
    localparam int FREQ_W   = 25;
    localparam int SUM_W    = 37;
    localparam int COUNT_W  = 12;
    localparam int INDEX_W  = 12;

    localparam int DEF_MAX_BLOCK     = 4096;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic [RATE_W-1:0]  RATE_RESET     = RATE_W'(48000);
    localparam logic [FREQ_W-1:0]  FREQ_MAX       = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [COUNT_W-1:0] MIN_MEAN_COUNT = COUNT_W'(2);

endpackage

### hw/rtl/zero_crossing_frequency_meter.sv
// ----------------------------------------------------------------------------
// zero_crossing_frequency_meter
// Rising zero crossing detector with interpolated timing, per-period
// frequency and block mean, all divisions on one serial divider.
// Each sample ends in a tail step. A crossing first runs the interpolation
// division, after the first crossing the frequency division, and the record
// step. After the final sample's tail the mean division runs when two or
// more periods were measured, then the result is loaded, held while stalled.
// One sample in flight at a time.
// Synchronous active-low reset clears all block state; sample rate -> 48000.
// ----------------------------------------------------------------------------
module zero_crossing_frequency_meter #(
    parameter int MAX_BLOCK     = zcfm_pkg::DEF_MAX_BLOCK,
    parameter int FRACTION_BITS = zcfm_pkg::DEF_FRACTION_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [zcfm_pkg::RATE_W-1:0]          i_cfg_wr_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [zcfm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                 i_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [zcfm_pkg::FREQ_W-1:0]          o_mean_frequency,
    output logic                                 o_frequency_valid,
    output logic                                 o_trigger_found,
    output logic [zcfm_pkg::INDEX_W-1:0]         o_trigger_index
);

    import zcfm_pkg::*;

    localparam int FB  = FRACTION_BITS;
    localparam int PW  = $clog2(MAX_BLOCK);
    localparam int TW  = PW + FB;
    localparam int DVW = (FB + 26 > SUM_W) ? FB + 26 : SUM_W;
    localparam int DSW = (TW > SAMPLE_W) ? TW : SAMPLE_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FRAC_GO   = 4'd1;
    localparam logic [3:0] S_FRAC_WAIT = 4'd2;
    localparam logic [3:0] S_FREQ_GO   = 4'd3;
    localparam logic [3:0] S_FREQ_WAIT = 4'd4;
    localparam logic [3:0] S_RECORD    = 4'd5;
    localparam logic [3:0] S_TAIL      = 4'd6;
    localparam logic [3:0] S_MEAN_GO   = 4'd7;
    localparam logic [3:0] S_MEAN_WAIT = 4'd8;
    localparam logic [3:0] S_OUT       = 4'd9;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic [RATE_W-1:0]         r_rate;
    logic [PW-1:0]             r_pos;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic                      r_final;
    logic [TW-1:0]             r_time;
    logic [TW-1:0]             r_last_time;
    logic                      r_seen;
    logic [SUM_W-1:0]          r_sum;
    logic [COUNT_W-1:0]        r_count;
    logic [PW-1:0]             r_first_idx;
    logic                      r_first_seen;

    logic                      r_out_valid;
    logic [FREQ_W-1:0]         r_out_mean;
    logic                      r_out_fvalid;
    logic                      r_out_found;
    logic [INDEX_W-1:0]        r_out_idx;

    logic                      in_accept;
    logic                      crossing;
    logic                      at_limit;
    logic                      out_free;
    logic                      mean_ok;
    logic [SAMPLE_W-1:0]       neg_prev;
    logic [SAMPLE_W-1:0]       span;
    logic [TW-1:0]             cross_time;
    logic [FREQ_W-1:0]         freq_sat;
    logic [INDEX_W+PW-1:0]     idx_ext;

    logic                      div_start;
    logic [DVW-1:0]            div_dividend;
    logic [DSW-1:0]            div_divisor;
    logic                      div_done;
    logic [DVW-1:0]            div_quo;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign at_limit   = (r_pos >= PW'(MAX_BLOCK - 1));
    assign crossing   = (r_pos != '0) && r_prev[SAMPLE_W-1] && !i_sample[SAMPLE_W-1] &&
                        (i_sample != '0);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign mean_ok    = (r_count >= MIN_MEAN_COUNT);

    assign neg_prev   = SAMPLE_W'(-r_prev);
    assign span       = SAMPLE_W'(r_cur - r_prev);
    assign cross_time = {r_pos - PW'(1), {FB{1'b0}}} + TW'(div_quo[FB-1:0]);
    assign freq_sat   = (div_quo > DVW'(FREQ_MAX)) ? FREQ_MAX : div_quo[FREQ_W-1:0];
    assign idx_ext    = {{INDEX_W{1'b0}}, r_first_idx};

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (r_state)
            S_FRAC_GO: begin
                div_start    = 1'b1;
                div_dividend = DVW'({neg_prev, {FB{1'b0}}});
                div_divisor  = DSW'(span);
            end
            S_FREQ_GO: begin
                div_start    = 1'b1;
                div_dividend = DVW'({r_rate, {(FB + 8){1'b0}}});
                div_divisor  = DSW'(r_time - r_last_time);
            end
            S_MEAN_GO: begin
                div_start    = 1'b1;
                div_dividend = DVW'(r_sum);
                div_divisor  = DSW'(r_count);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    zcfm_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = crossing ? S_FRAC_GO : S_TAIL;
            end
            S_FRAC_GO:   n_state = S_FRAC_WAIT;
            S_FRAC_WAIT: begin
                if (div_done) n_state = r_seen ? S_FREQ_GO : S_RECORD;
            end
            S_FREQ_GO:   n_state = S_FREQ_WAIT;
            S_FREQ_WAIT: begin
                if (div_done) n_state = S_RECORD;
            end
            S_RECORD:    n_state = S_TAIL;
            S_TAIL: begin
                if (!r_final)    n_state = S_IDLE;
                else if (mean_ok) n_state = S_MEAN_GO;
                else             n_state = S_OUT;
            end
            S_MEAN_GO:   n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rate       <= RATE_RESET;
            r_pos        <= '0;
            r_prev       <= '0;
            r_last_time  <= '0;
            r_seen       <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
            r_first_idx  <= '0;
            r_first_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_rate <= i_cfg_wr_data;
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;

            case (r_state)
                S_FREQ_WAIT: begin
                    if (div_done) begin
                        r_sum <= r_sum + SUM_W'(freq_sat);
                        if (r_count != COUNT_MAX) r_count <= r_count + COUNT_W'(1);
                    end
                end
                S_RECORD: begin
                    r_last_time <= r_time;
                    r_seen      <= 1'b1;
                    if (!r_first_seen) begin
                        r_first_seen <= 1'b1;
                        r_first_idx  <= r_pos;
                    end
                end
                S_TAIL: begin
                    r_prev <= r_cur;
                    if (!r_final) r_pos <= r_pos + PW'(1);
                end
                S_OUT: begin
                    if (out_free) begin
                        r_pos        <= '0;
                        r_prev       <= '0;
                        r_last_time  <= '0;
                        r_seen       <= 1'b0;
                        r_sum        <= '0;
                        r_count      <= '0;
                        r_first_idx  <= '0;
                        r_first_seen <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cur   <= i_sample;
            r_final <= i_last || at_limit;
        end
        if (r_state == S_FRAC_WAIT && div_done) r_time <= cross_time;
        if (r_state == S_OUT && out_free) begin
            r_out_mean   <= mean_ok ? div_quo[FREQ_W-1:0] : '0;
            r_out_fvalid <= mean_ok;
            r_out_found  <= r_first_seen;
            r_out_idx    <= r_first_seen ? idx_ext[INDEX_W-1:0] : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_mean_frequency  = r_out_mean;
    assign o_frequency_valid = r_out_fvalid;
    assign o_trigger_found   = r_out_found;
    assign o_trigger_index   = r_out_idx;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_FRAC_WAIT || r_state == S_FREQ_WAIT ||
                      r_state == S_MEAN_WAIT))
        else $error("divider finished outside a wait state");

    a_seen_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen == r_first_seen)
        else $error("crossing flags disagree");

    a_count_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_seen)
        else $error("frequency counted without a prior crossing");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !out_free) |=> (r_state == S_OUT && r_out_valid))
        else $error("result dropped while output register was stalled");

endmodule

### hw/rtl/zcfm_div.sv
// ----------------------------------------------------------------------------
// zcfm_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module zcfm_div #(
    parameter int DVW = 42,
    parameter int DSW = 28
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [DSW-1:0] i_divisor,
    output logic           o_done,
    output logic [DVW-1:0] o_quotient
);

    localparam int CW = $clog2(DVW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [DSW-1:0] r_rem;
    logic [DSW-1:0] r_div;
    logic [DVW-1:0] r_quo;

    logic [DSW:0]   trial;
    logic           fits;

    assign trial = {r_rem, r_quo[DVW-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? DSW'(trial - {1'b0, r_div}) : trial[DSW-1:0];
            r_quo <= {r_quo[DVW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### test/tb_zero_crossing_frequency_meter.sv
// ----------------------------------------------------------------------------
// tb_zero_crossing_frequency_meter
// Streams blocks of signed audio samples into the zero crossing frequency
// meter under bursty input traffic and random output stalls. Each accepted
// sample also runs through a local model of the crossing interpolation,
// per-period frequency and block mean. The block summaries that come out
// are checked field by field against that model, across several sample
// rates. The rates include both ends of the randomly drawn range.
// ----------------------------------------------------------------------------
module tb_zero_crossing_frequency_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import zcfm_pkg::*;

    localparam int  MAX_BLOCK     = DEF_MAX_BLOCK;
    localparam int  FRAC_BITS     = DEF_FRACTION_BITS;
    localparam int  SETTLE_CYCLES = 200;
    localparam int  PHASE_ITEMS   = 280;
    localparam logic [RATE_W-1:0] RATE_LOW  = RATE_W'(1000);
    localparam logic [RATE_W-1:0] RATE_HIGH = RATE_W'(192000);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_sample_req;

    typedef struct packed {
        logic [FREQ_W-1:0]  mean_frequency;
        logic               frequency_valid;
        logic               trigger_found;
        logic [INDEX_W-1:0] trigger_index;
    } t_block_summary;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [RATE_W-1:0]          i_cfg_wr_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_last = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [FREQ_W-1:0]          o_mean_frequency;
    logic                       o_frequency_valid;
    logic                       o_trigger_found;
    logic [INDEX_W-1:0]         o_trigger_index;

    zero_crossing_frequency_meter #(
        .MAX_BLOCK     (MAX_BLOCK),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_sample          (i_sample),
        .i_last            (i_last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_mean_frequency  (o_mean_frequency),
        .o_frequency_valid (o_frequency_valid),
        .o_trigger_found   (o_trigger_found),
        .o_trigger_index   (o_trigger_index)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_sample_req    sample_queue[$];
    t_block_summary expected_summaries[$];

    int fail_count     = 0;
    int accepted_count = 0;
    int summary_count  = 0;
    int found_count    = 0;
    int mean_count     = 0;
    int rate_writes    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_mode     = 0;
    int stall_run      = 0;

    logic [RATE_W-1:0]  rate_hz = RATE_RESET;
    int                 position;
    longint             prev_value;
    longint             prev_cross_time;
    bit                 cross_seen;
    logic [SUM_W-1:0]   freq_sum;
    logic [COUNT_W-1:0] freq_count;
    logic [INDEX_W-1:0] first_index;
    bit                 first_seen;

    function automatic void clear_meter();
        position        = 0;
        prev_value      = 0;
        prev_cross_time = 0;
        cross_seen      = 1'b0;
        freq_sum        = '0;
        freq_count      = '0;
        first_index     = '0;
        first_seen      = 1'b0;
    endfunction

    function automatic void measure_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
        longint         cur;
        longint         frac;
        longint         t;
        longint         interval;
        longint         freq;
        bit             ends;
        t_block_summary res;
        cur  = longint'(signed'(smp));
        ends = lst || (position >= MAX_BLOCK - 1);
        if (position > 0 && prev_value < 0 && cur > 0) begin
            frac = ((-prev_value) << FRAC_BITS) / (cur - prev_value);
            t    = (longint'(position - 1) << FRAC_BITS) + frac;
            if (cross_seen) begin
                interval = t - prev_cross_time;
                if (interval == 0)
                    freq = longint'(FREQ_MAX);
                else
                    freq = (longint'(rate_hz) << (FRAC_BITS + 8)) / interval;
                if (freq > longint'(FREQ_MAX))
                    freq = longint'(FREQ_MAX);
                freq_sum = freq_sum + SUM_W'(freq);
                if (freq_count != COUNT_MAX)
                    freq_count = freq_count + 1'b1;
            end
            prev_cross_time = t;
            cross_seen      = 1'b1;
            if (!first_seen) begin
                first_seen  = 1'b1;
                first_index = INDEX_W'(position);
            end
        end
        prev_value = cur;
        if (!ends) begin
            position++;
            return;
        end
        if (freq_count >= MIN_MEAN_COUNT) begin
            res.mean_frequency  = FREQ_W'(freq_sum / freq_count);
            res.frequency_valid = 1'b1;
        end else begin
            res.mean_frequency  = '0;
            res.frequency_valid = 1'b0;
        end
        res.trigger_found = first_seen;
        res.trigger_index = first_seen ? first_index : '0;
        expected_summaries = {expected_summaries, res};
        clear_meter();
    endfunction

    // Driver: bursts of requests separated by random gaps.
    always @(posedge i_clk) begin : drive_proc
        t_sample_req next_req;
        bit          next_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                measure_sample(i_sample, i_last);
                accepted_count++;
            end
            if (!i_in_valid || !o_in_stall) begin
                next_valid = 1'b0;
                next_req   = '{sample: i_sample, last: i_last};
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_queue.size() > 0) begin
                    next_req   = sample_queue.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                    end
                end
                i_in_valid <= next_valid;
                i_sample   <= next_req.sample;
                i_last     <= next_req.last;
            end
        end
    end

    // Receiver stall pattern: stretches of free flow, light, heavy and near-total stall.
    always @(posedge i_clk) begin : stall_proc
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_run  = $urandom_range(20, 200);
            end else begin
                stall_run--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_block_summary want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_summaries.size() == 0) begin
                $error("summary with none expected: mean %0d valid %0d found %0d index %0d",
                       o_mean_frequency, o_frequency_valid, o_trigger_found, o_trigger_index);
                fail_count++;
            end else begin
                want = expected_summaries.pop_front();
                summary_count++;
                if (want.trigger_found)
                    found_count++;
                if (want.frequency_valid)
                    mean_count++;
                if (o_mean_frequency !== want.mean_frequency) begin
                    $error("mean_frequency: expected %0d, got %0d",
                           want.mean_frequency, o_mean_frequency);
                    fail_count++;
                end
                if (o_frequency_valid !== want.frequency_valid) begin
                    $error("frequency_valid: expected %0d, got %0d",
                           want.frequency_valid, o_frequency_valid);
                    fail_count++;
                end
                if (o_trigger_found !== want.trigger_found) begin
                    $error("trigger_found: expected %0d, got %0d",
                           want.trigger_found, o_trigger_found);
                    fail_count++;
                end
                if (o_trigger_index !== want.trigger_index) begin
                    $error("trigger_index: expected %0d, got %0d",
                           want.trigger_index, o_trigger_index);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_sample(input int value, input bit lst);
        t_sample_req req;
        req          = '{sample: value[SAMPLE_W-1:0], last: lst};
        sample_queue = {sample_queue, req};
    endtask

    task automatic push_block(input int len, input int shape);
        int half;
        int amp;
        int mag;
        int run;
        int k;
        int value;
        bit positive;
        half     = $urandom_range(1, 24);
        amp      = $urandom_range(0, 1) ? $urandom_range(1, 100) : $urandom_range(1, 8388607);
        positive = $urandom_range(0, 1);
        run      = 0;
        for (k = 0; k < len; k++) begin
            if (shape == 0) begin
                value = $urandom;
            end else begin
                if (run >= half) begin
                    run      = 0;
                    positive = !positive;
                    if ($urandom_range(0, 3) == 0)
                        half = $urandom_range(1, 24);
                end
                mag = $urandom_range(1, amp);
                if ($urandom_range(0, 15) == 0)
                    value = 0;
                else
                    value = positive ? mag : -mag;
                run++;
            end
            push_sample(value, k == len - 1);
        end
    endtask

    task automatic push_random_phase();
        int pushed;
        int len;
        pushed = 0;
        while (pushed < PHASE_ITEMS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
            push_block(len, ($urandom_range(0, 4) == 0) ? 0 : 1);
            pushed += len;
        end
    endtask

    task automatic wait_idle();
        while (sample_queue.size() > 0 || i_in_valid || expected_summaries.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        rate_hz = value;
        rate_writes++;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin : main_proc
        int phase;
        clear_meter();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_sample(-8388608, 1'b1);
        push_sample(0, 1'b0);
        push_sample(-5, 1'b0);
        push_sample(0, 1'b0);
        push_sample(7, 1'b1);
        push_sample(8388607, 1'b0);
        push_sample(-8388608, 1'b1);
        push_sample(50, 1'b0);
        push_sample(-3, 1'b0);
        push_sample(3, 1'b0);
        push_sample(-3, 1'b0);
        push_sample(3, 1'b1);
        wait_idle();

        write_rate(RATE_HIGH);
        push_sample(-8388608, 1'b0);
        push_sample(1, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(8388607, 1'b0);
        push_sample(-8388608, 1'b0);
        push_sample(1, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(8388607, 1'b1);
        wait_idle();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_rate(RATE_LOW);
                1: write_rate(RATE_HIGH);
                4: write_rate(RATE_RESET);
                default: write_rate(RATE_W'($urandom_range(1000, 192000)));
            endcase
            push_random_phase();
            wait_idle();
        end

        $display("%0d samples accepted in %0d blocks over %0d rate writes", accepted_count,
                 summary_count, rate_writes);
        $display("%0d blocks had a crossing, %0d produced a mean frequency", found_count,
                 mean_count);
        if (fail_count == 0)
            $display("zero_crossing_frequency_meter verification clean");
        else
            $display("zero_crossing_frequency_meter verification failed");
        $finish;
    end

    initial begin : timeout_proc
        #40ms;
        $display("zero_crossing_frequency_meter verification failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/zcfm_pkg.sv
hw/rtl/zcfm_div.sv
hw/rtl/zero_crossing_frequency_meter.sv
test/tb_zero_crossing_frequency_meter.sv
